>>> hdl/imu_att_pkg.sv
package imu_att_pkg;

    localparam int BYTE_W = 8;
    localparam int YAW_W  = 16;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;

    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET = 8'd20;
    localparam logic [BYTE_W-1:0] ATTITUDE_ID_RESET = 8'd1;

    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTITUDE_ID = 1'b1;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage

>>> hdl/imu_attitude_frame_parser.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall   rx_byte
// result    out        out_valid / out_stall frame_id, checksum_ok, yaw_updated, yaw_angle
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte is taken per cycle when not stalled; frame state is updated in the same cycle.
// The result for a checksum byte is in the output register the cycle after it is taken.
// Input is stalled only while a checksum byte is due and a stalled result is still held.
// Reset is asynchronous and returns the parser to waiting for the first sync byte.
// The configuration port is always ready and takes one register write per cycle.
module imu_attitude_frame_parser
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          rx_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          frame_id,
    output logic                                checksum_ok,
    output logic                                yaw_updated,
    output logic signed [15:0]                  yaw_angle,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [imu_att_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                          cfg_data
);

    localparam logic [2:0] PH_SYNC1 = 3'd0;
    localparam logic [2:0] PH_SYNC2 = 3'd1;
    localparam logic [2:0] PH_ID    = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_SUM   = 3'd5;

    logic [2:0]          phase_reg, phase_next;
    imu_att_pkg::byte_t  held_id_reg, held_id_next;
    imu_att_pkg::byte_t  length_reg, length_next;
    imu_att_pkg::byte_t  count_reg, count_next;
    imu_att_pkg::byte_t  sum_reg, sum_next;
    imu_att_pkg::byte_t  yaw_lo_reg, yaw_lo_next;
    imu_att_pkg::byte_t  yaw_hi_reg, yaw_hi_next;
    imu_att_pkg::byte_t  max_payload_reg;
    imu_att_pkg::byte_t  attitude_id_reg;

    logic                out_valid_reg;
    imu_att_pkg::byte_t  frame_id_reg;
    logic                checksum_ok_reg;
    logic                yaw_updated_reg;
    logic signed [15:0]  yaw_angle_reg;

    logic                accept;
    logic                sum_ok;
    logic                upd;
    imu_att_pkg::byte_t  count_inc;
    imu_att_pkg::byte_t  sum_add;

    assign in_stall  = out_valid_reg && out_stall && (phase_reg == PH_SUM);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign count_inc = count_reg + 8'd1;
    assign sum_add   = sum_reg + rx_byte;
    assign sum_ok    = (sum_reg == rx_byte);
    assign upd       = sum_ok && (held_id_reg == attitude_id_reg);

    always_comb
    begin
        phase_next   = phase_reg;
        held_id_next = held_id_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        yaw_lo_next  = yaw_lo_reg;
        yaw_hi_next  = yaw_hi_reg;
        unique case (phase_reg)
            PH_SYNC2:
            begin
                if (rx_byte == imu_att_pkg::SYNC_BYTE)
                begin
                    sum_next   = sum_add;
                    phase_next = PH_ID;
                end
                else
                begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_ID:
            begin
                held_id_next = rx_byte;
                sum_next     = sum_add;
                phase_next   = PH_LEN;
            end
            PH_LEN:
            begin
                length_next = rx_byte;
                sum_next    = sum_add;
                count_next  = '0;
                phase_next  = (rx_byte > max_payload_reg) ? PH_SYNC1 : PH_DATA;
            end
            PH_DATA:
            begin
                if (count_reg == 8'd4)
                begin
                    yaw_lo_next = rx_byte;
                end
                else if (count_reg == 8'd5)
                begin
                    yaw_hi_next = rx_byte;
                end
                count_next = count_inc;
                sum_next   = sum_add;
                if (count_inc >= length_reg)
                begin
                    phase_next = PH_SUM;
                end
            end
            PH_SUM:
            begin
                phase_next = PH_SYNC1;
            end
            default:
            begin
                if (rx_byte == imu_att_pkg::SYNC_BYTE)
                begin
                    sum_next   = rx_byte;
                    phase_next = PH_SYNC2;
                end
                else
                begin
                    phase_next = PH_SYNC1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SYNC1;
            held_id_reg <= '0;
            length_reg  <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            yaw_lo_reg  <= '0;
            yaw_hi_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            held_id_reg <= held_id_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            yaw_lo_reg  <= yaw_lo_next;
            yaw_hi_reg  <= yaw_hi_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= imu_att_pkg::MAX_PAYLOAD_RESET;
            attitude_id_reg <= imu_att_pkg::ATTITUDE_ID_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                imu_att_pkg::CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                imu_att_pkg::CFG_ATTITUDE_ID: attitude_id_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && (phase_reg == PH_SUM))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (phase_reg == PH_SUM))
        begin
            frame_id_reg    <= held_id_reg;
            checksum_ok_reg <= sum_ok;
            yaw_updated_reg <= upd;
            yaw_angle_reg   <= upd ? signed'({yaw_hi_reg, yaw_lo_reg}) : 16'sd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_id    = frame_id_reg;
    assign checksum_ok = checksum_ok_reg;
    assign yaw_updated = yaw_updated_reg;
    assign yaw_angle   = yaw_angle_reg;

endmodule

>>> hdl/imu_att_checker.sv
module imu_att_checker
(
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic [7:0]                             frame_id,
    input logic                                   checksum_ok,
    input logic                                   yaw_updated,
    input logic signed [imu_att_pkg::YAW_W-1:0]   yaw_angle
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("Stalled result request was withdrawn.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(frame_id) && $stable(yaw_angle))
        else $error("Stalled result request changed its payload.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !checksum_ok |-> !yaw_updated)
        else $error("Yaw reported as updated on a failed checksum.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !yaw_updated |-> yaw_angle == '0)
        else $error("Yaw angle not zero without an update.");

endmodule

bind imu_attitude_frame_parser imu_att_checker u_imu_att_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_id    (frame_id),
    .checksum_ok (checksum_ok),
    .yaw_updated (yaw_updated),
    .yaw_angle   (yaw_angle)
);

>>> bench/tb_imu_attitude_frame_parser.sv
module tb_imu_attitude_frame_parser;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 400;

    typedef imu_att_pkg::byte_t byte_t;

    typedef enum logic [2:0] {
        WAIT_SYNC1,
        WAIT_SYNC2,
        TAKE_ID,
        TAKE_LEN,
        TAKE_DATA,
        TAKE_SUM
    } parse_phase_t;

    typedef struct {
        byte_t       id;
        logic        ok;
        logic        upd;
        logic [15:0] yaw;
    } frame_result_t;

    typedef struct {
        byte_t         sync2;
        byte_t         id;
        byte_t         len;
        byte_t         lo;
        byte_t         hi;
        byte_t         fill;
        byte_t         flip;
        bit            has_want;
        frame_result_t want;
    } frame_row_t;

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic [7:0]                        rx_byte;
    logic                              out_valid;
    logic                              out_stall;
    logic [7:0]                        frame_id;
    logic                              checksum_ok;
    logic                              yaw_updated;
    logic signed [15:0]                yaw_angle;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [imu_att_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [7:0]                        cfg_data;

    byte_t         max_len_cfg = imu_att_pkg::MAX_PAYLOAD_RESET;
    byte_t         att_id_cfg  = imu_att_pkg::ATTITUDE_ID_RESET;
    parse_phase_t  ph          = WAIT_SYNC1;
    byte_t         cur_id      = '0;
    byte_t         cur_len     = '0;
    byte_t         cur_count   = '0;
    byte_t         cur_sum     = '0;
    byte_t         yaw_lo_q    = '0;
    byte_t         yaw_hi_q    = '0;

    frame_result_t frames_due[$];
    frame_result_t typed_result;
    bit            typed_armed = 1'b0;
    int            mismatches  = 0;
    int            bytes_sent  = 0;
    int            idle_cycles = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    bit            hold_req    = 1'b0;
    frame_row_t    directed_rows [0:14];

    imu_attitude_frame_parser dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_id    (frame_id),
        .checksum_ok (checksum_ok),
        .yaw_updated (yaw_updated),
        .yaw_angle   (yaw_angle),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic advance_parser(input byte_t b);
        frame_result_t r;
        begin
            case (ph)
                WAIT_SYNC2:
                begin
                    if (b == imu_att_pkg::SYNC_BYTE)
                    begin
                        cur_sum += b;
                        ph = TAKE_ID;
                    end
                    else
                        ph = WAIT_SYNC1;
                end
                TAKE_ID:
                begin
                    cur_id = b;
                    cur_sum += b;
                    ph = TAKE_LEN;
                end
                TAKE_LEN:
                begin
                    cur_len = b;
                    cur_sum += b;
                    cur_count = '0;
                    if (b > max_len_cfg)
                        ph = WAIT_SYNC1;
                    else
                        ph = TAKE_DATA;
                end
                TAKE_DATA:
                begin
                    if (cur_count == 8'd4)
                        yaw_lo_q = b;
                    else if (cur_count == 8'd5)
                        yaw_hi_q = b;
                    cur_count += 8'd1;
                    cur_sum += b;
                    if (cur_count >= cur_len)
                        ph = TAKE_SUM;
                end
                TAKE_SUM:
                begin
                    r.id  = cur_id;
                    r.ok  = (cur_sum == b);
                    r.upd = r.ok && (cur_id == att_id_cfg);
                    r.yaw = r.upd ? {yaw_hi_q, yaw_lo_q} : 16'h0000;
                    if (typed_armed)
                    begin
                        frames_due.push_back(typed_result);
                        typed_armed = 1'b0;
                    end
                    else
                        frames_due.push_back(r);
                    ph = WAIT_SYNC1;
                end
                default:
                begin
                    if (b == imu_att_pkg::SYNC_BYTE)
                    begin
                        cur_sum = b;
                        ph = WAIT_SYNC2;
                    end
                    else
                        ph = WAIT_SYNC1;
                end
            endcase
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_stall === 1'b0)
            advance_parser(rx_byte);
    end

    always @(posedge clk)
    begin
        frame_result_t e;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (frames_due.size() == 0)
            begin
                $display("%0t: unexpected result id=%h ok=%b upd=%b yaw=%h",
                         $time, frame_id, checksum_ok, yaw_updated, yaw_angle);
                mismatches++;
            end
            else
            begin
                e = frames_due.pop_front();
                if (frame_id !== e.id)
                begin
                    $display("%0t: frame_id expected %h actual %h", $time, e.id, frame_id);
                    mismatches++;
                end
                if (checksum_ok !== e.ok)
                begin
                    $display("%0t: checksum_ok expected %b actual %b",
                             $time, e.ok, checksum_ok);
                    mismatches++;
                end
                if (yaw_updated !== e.upd)
                begin
                    $display("%0t: yaw_updated expected %b actual %b",
                             $time, e.upd, yaw_updated);
                    mismatches++;
                end
                if (yaw_angle !== e.yaw)
                begin
                    $display("%0t: yaw_angle expected %h actual %h", $time, e.yaw, yaw_angle);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
            (cfg_valid && cfg_ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // The receiver either stalls at random or, on request, holds off for a long stretch.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic push_byte(input byte_t b);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            rx_byte  <= b;
            @(posedge clk);
            while (in_stall !== 1'b0)
                @(posedge clk);
            bytes_sent++;
        end
    endtask

    task automatic send_frame(input byte_t sync2, input byte_t id, input byte_t len,
                              input byte_t lo, input byte_t hi, input byte_t fill,
                              input byte_t flip, input bit scramble, input int cut,
                              input bit arm, input frame_result_t want);
        byte_t q[$];
        byte_t sum;
        byte_t d;
        int    n;
        begin
            q.push_back(imu_att_pkg::SYNC_BYTE);
            q.push_back(sync2);
            if (sync2 == imu_att_pkg::SYNC_BYTE)
            begin
                q.push_back(id);
                q.push_back(len);
                if (len <= max_len_cfg)
                begin
                    n = (len == 0) ? 1 : len;
                    for (int k = 0; k < n; k++)
                    begin
                        if (k == 4)
                            d = lo;
                        else if (k == 5)
                            d = hi;
                        else
                            d = scramble ? byte_t'($urandom) : fill;
                        q.push_back(d);
                    end
                    sum = '0;
                    foreach (q[i])
                        sum += q[i];
                    q.push_back(sum ^ flip);
                end
            end
            for (int i = 0; i < q.size() && i < cut; i++)
            begin
                // The typed result is armed only for the checksum request itself.
                if (arm && i == q.size() - 1)
                begin
                    typed_result = want;
                    typed_armed  = 1'b1;
                end
                push_byte(q[i]);
            end
        end
    endtask

    task automatic settle();
        begin
            in_valid <= 1'b0;
            while (frames_due.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic write_config(input byte_t max_len, input byte_t att);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= imu_att_pkg::CFG_MAX_PAYLOAD;
            cfg_data  <= max_len;
            @(posedge clk);
            while (cfg_ready !== 1'b1)
                @(posedge clk);
            max_len_cfg = max_len;
            cfg_index <= imu_att_pkg::CFG_ATTITUDE_ID;
            cfg_data  <= att;
            @(posedge clk);
            while (cfg_ready !== 1'b1)
                @(posedge clk);
            att_id_cfg = att;
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic run_random_frames(input int count);
        frame_result_t none;
        int            stop_at;
        int            r;
        int            cap;
        byte_t         len;
        byte_t         id;
        byte_t         flip;
        begin
            none    = '{default: '0};
            stop_at = bytes_sent + count;
            cap     = (max_len_cfg < 8) ? max_len_cfg : 8;
            while (bytes_sent < stop_at)
            begin
                r = $urandom_range(99);
                if (r < 8)
                    push_byte(byte_t'($urandom));
                else if (r < 12)
                    send_frame(byte_t'($urandom), byte_t'($urandom), 8'd0, 8'd0, 8'd0,
                               8'd0, 8'd0, 1'b1, 1000, 1'b0, none);
                else if (r < 17)
                    send_frame(imu_att_pkg::SYNC_BYTE, att_id_cfg,
                               byte_t'($urandom_range(0, cap)),
                               8'd0, 8'd0, 8'd0, 8'd0, 1'b1, $urandom_range(1, 6),
                               1'b0, none);
                else
                begin
                    if ($urandom_range(24) == 0)
                        len = byte_t'($urandom);
                    else if ($urandom_range(9) == 0)
                        len = byte_t'(cap + 1);
                    else
                        len = byte_t'($urandom_range(0, cap));
                    id   = ($urandom_range(2) != 0) ? att_id_cfg : byte_t'($urandom);
                    flip = ($urandom_range(7) == 0) ? byte_t'($urandom_range(1, 255)) : 8'd0;
                    send_frame(imu_att_pkg::SYNC_BYTE, id, len, byte_t'($urandom),
                               byte_t'($urandom), 8'd0, flip, 1'b1, 1000, 1'b0, none);
                end
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        // Reset configuration: longest payload 20, attitude id 1.
        directed_rows = '{
            '{8'h55, 8'h01, 8'd6,   8'h34, 8'h12, 8'h00, 8'h00, 1'b1,
              '{8'h01, 1'b1, 1'b1, 16'h1234}},
            '{8'h55, 8'h01, 8'd6,   8'hFF, 8'h7F, 8'h00, 8'h00, 1'b1,
              '{8'h01, 1'b1, 1'b1, 16'h7FFF}},
            '{8'h55, 8'h01, 8'd6,   8'h00, 8'h80, 8'hFF, 8'h00, 1'b1,
              '{8'h01, 1'b1, 1'b1, 16'h8000}},
            '{8'h55, 8'h01, 8'd20,  8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1,
              '{8'h01, 1'b1, 1'b1, 16'hFFFF}},
            '{8'h55, 8'h01, 8'd21,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
              '{8'h00, 1'b0, 1'b0, 16'h0000}},
            '{8'h55, 8'h02, 8'd6,   8'hAA, 8'h55, 8'h00, 8'h00, 1'b1,
              '{8'h02, 1'b1, 1'b0, 16'h0000}},
            '{8'h55, 8'h01, 8'd6,   8'h11, 8'h22, 8'h00, 8'h01, 1'b1,
              '{8'h01, 1'b0, 1'b0, 16'h0000}},
            '{8'h55, 8'h01, 8'd0,   8'h00, 8'h00, 8'h5A, 8'h00, 1'b0,
              '{8'h00, 1'b0, 1'b0, 16'h0000}},
            '{8'h55, 8'h01, 8'd3,   8'h00, 8'h00, 8'h0F, 8'h00, 1'b0,
              '{8'h00, 1'b0, 1'b0, 16'h0000}},
            '{8'hAA, 8'h00, 8'd0,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
              '{8'h00, 1'b0, 1'b0, 16'h0000}},
            '{8'h55, 8'h55, 8'd6,   8'h01, 8'h00, 8'h00, 8'h00, 1'b1,
              '{8'h55, 1'b1, 1'b0, 16'h0000}},
            '{8'h55, 8'hFF, 8'd0,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
              '{8'hFF, 1'b1, 1'b0, 16'h0000}},
            '{8'h55, 8'h00, 8'd255, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
              '{8'h00, 1'b0, 1'b0, 16'h0000}},
            '{8'h55, 8'h00, 8'd1,   8'h00, 8'h00, 8'hF0, 8'h80, 1'b1,
              '{8'h00, 1'b0, 1'b0, 16'h0000}},
            '{8'h55, 8'h01, 8'd5,   8'h77, 8'h00, 8'h00, 8'h00, 1'b0,
              '{8'h00, 1'b0, 1'b0, 16'h0000}}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 22;
        recv_idle_pct = 64;
        foreach (directed_rows[i])
            send_frame(directed_rows[i].sync2, directed_rows[i].id, directed_rows[i].len,
                       directed_rows[i].lo, directed_rows[i].hi, directed_rows[i].fill,
                       directed_rows[i].flip, 1'b0, 1000, directed_rows[i].has_want,
                       directed_rows[i].want);

        settle();
        write_config(8'd0, 8'd0);
        run_random_frames(110);
        settle();
        write_config(8'd255, 8'd255);
        run_random_frames(130);

        send_idle_pct = 64;
        recv_idle_pct = 22;
        settle();
        write_config(byte_t'($urandom_range(1, 30)), byte_t'($urandom));
        run_random_frames(130);
        settle();
        write_config(8'd7, 8'd1);
        run_random_frames(110);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        settle();
        write_config(8'd5, 8'd1);
        hold_req = 1'b1;
        run_random_frames(120);
        settle();
        write_config(byte_t'($urandom), byte_t'($urandom));
        run_random_frames(120);

        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && frames_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
        begin
            if (frames_due.size() != 0)
                $display("%0t: %0d expected results never arrived", $time, frames_due.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
